FILE: hw/rtl/atil_pkg.sv
// Shared types, widths and the arctangent table for the tilt angle pipeline.
// Used by the square root cells, the rotation cells and the top level.
`timescale 1ns / 1ps

package atil_pkg;

    // Datapath widths are sized for the smallest sample shift, so they hold for any shift.
    localparam int CNT_W   = 16;           // signed axis count
    localparam int SQ_W    = 32;           // square and sum of two squares
    localparam int ROOT_W  = 30;           // pair magnitude in units of 2^-14 count
    localparam int REM_W   = 34;           // partial remainder of the root extraction
    localparam int RAD_PAD = 28;           // zero bits appended below the sum
    localparam int SQ_STEPS = ROOT_W;      // one result bit per root cell
    localparam int MAG_SHIFT = 14;
    localparam int XY_W    = 34;           // rotation x and y words
    localparam int Z_W     = 32;           // accumulated angle, degrees times 2^24
    localparam int TAB_FRAC = 24;
    localparam int ANGLE_W = 16;
    localparam logic signed [Z_W-1:0] RIGHT_ANGLE = 32'sd1509949440;

    typedef struct packed {
        logic signed [CNT_W-1:0] cx;
        logic signed [CNT_W-1:0] cy;
        logic signed [CNT_W-1:0] cz;
    } t_counts;

    // atan(2^-i) in degrees times 2^24, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:  v = 32'sd754974720;
            1:  v = 32'sd445687602;
            2:  v = 32'sd235489088;
            3:  v = 32'sd119537938;
            4:  v = 32'sd60000934;
            5:  v = 32'sd30029717;
            6:  v = 32'sd15018523;
            7:  v = 32'sd7509720;
            8:  v = 32'sd3754917;
            9:  v = 32'sd1877466;
            10: v = 32'sd938734;
            11: v = 32'sd469367;
            12: v = 32'sd234684;
            13: v = 32'sd117342;
            14: v = 32'sd58671;
            15: v = 32'sd29335;
            16: v = 32'sd14668;
            17: v = 32'sd7334;
            18: v = 32'sd3667;
            19: v = 32'sd1833;
            20: v = 32'sd917;
            21: v = 32'sd458;
            22: v = 32'sd229;
            23: v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/atil_sqrt_cell.sv
// One cell of the digit-by-digit square root chain: one result bit per cell.
// Depends on atil_pkg for widths.
`timescale 1ns / 1ps

module atil_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [atil_pkg::SQ_W-1:0]       i_rad,
    input  logic [atil_pkg::REM_W-1:0]      i_rem,
    input  logic [atil_pkg::ROOT_W-1:0]     i_root,
    output logic [atil_pkg::SQ_W-1:0]       o_rad,
    output logic [atil_pkg::REM_W-1:0]      o_rem,
    output logic [atil_pkg::ROOT_W-1:0]     o_root
);

    logic [atil_pkg::SQ_W+atil_pkg::RAD_PAD-1:0] w_full;
    logic [atil_pkg::REM_W-1:0] w_cur;
    logic [atil_pkg::REM_W-1:0] w_trial;
    logic [atil_pkg::SQ_W-1:0]  r_rad;
    logic [atil_pkg::REM_W-1:0] r_rem, n_rem;
    logic [atil_pkg::ROOT_W-1:0] r_root, n_root;

    assign w_full  = {i_rad, {atil_pkg::RAD_PAD{1'b0}}};
    assign w_cur   = {i_rem[atil_pkg::REM_W-3:0], w_full[2*STEP+1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};

    always_comb begin
        if (w_cur >= w_trial) begin
            n_rem  = w_cur - w_trial;
            n_root = {i_root[atil_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_cur;
            n_root = {i_root[atil_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/atil_cordic_cell.sv
// One vectoring rotation cell of the arctangent chain.
// Depends on atil_pkg for widths and the angle table.
`timescale 1ns / 1ps

module atil_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [atil_pkg::XY_W-1:0]    i_x,
    input  logic signed [atil_pkg::XY_W-1:0]    i_y,
    input  logic signed [atil_pkg::Z_W-1:0]     i_z,
    output logic signed [atil_pkg::XY_W-1:0]    o_x,
    output logic signed [atil_pkg::XY_W-1:0]    o_y,
    output logic signed [atil_pkg::Z_W-1:0]     o_z
);

    localparam logic signed [atil_pkg::Z_W-1:0] T = atil_pkg::atan_entry(STEP);

    logic signed [atil_pkg::XY_W-1:0] w_xs, w_ys;
    logic signed [atil_pkg::XY_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [atil_pkg::Z_W-1:0]  r_z, n_z;

    assign w_xs = i_x >>> STEP;
    assign w_ys = i_y >>> STEP;

    always_comb begin
        if (!i_y[atil_pkg::XY_W-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + T;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - T;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hw/rtl/accel_tilt_angles.sv
// Top level of the accelerometer tilt angle pipeline.
// Depends on atil_pkg, atil_sqrt_cell and atil_cordic_cell.
`timescale 1ns / 1ps

// Takes one sample (three left-justified axis words) per transaction and returns pitch,
// roll and incline in degrees with ANGLE_FRAC_BITS fraction bits, plus the all-zero flags.
// The pipeline accepts one sample every cycle while the output is not stalled; the delay of a
// result after its sample is set by the 30 cells of the square root chain and the rotation
// cells. A stall on the output side holds the whole pipeline.
module accel_tilt_angles #(
    parameter int SAMPLE_SHIFT    = 6,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // accel_x_word, accel_y_word, accel_z_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // pitch_angle, roll_angle, incline_angle
    output logic [2:0]  o_m_tuser    // pitch_invalid, roll_invalid, incline_invalid
);

    localparam int NS  = CORDIC_STAGES;
    localparam int SQN = atil_pkg::SQ_STEPS;
    localparam int P   = 3 + SQN + NS + 1;     // pipeline stages before the output register
    localparam int SD  = 2 + SQN + NS;         // side line from the square stage to the end
    localparam int SH  = atil_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [31:0] HALF = 32'sd1 <<< (SH - 1);

    logic w_adv;
    logic [P-1:0] r_vld;
    logic r_out_v;
    logic [47:0] r_out_data;
    logic [2:0]  r_out_user;

    assign w_adv      = !r_out_v || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_vld   <= {r_vld[P-2:0], i_s_tvalid};
            r_out_v <= r_vld[P-1];
        end
    end

    // Stage 0: axis counts.
    atil_pkg::t_counts r_cnt;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cnt.cx <= $signed(i_s_tdata[15:0])  >>> SAMPLE_SHIFT;
            r_cnt.cy <= $signed(i_s_tdata[31:16]) >>> SAMPLE_SHIFT;
            r_cnt.cz <= $signed(i_s_tdata[47:32]) >>> SAMPLE_SHIFT;
        end
    end

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        if (e < 0) e = -e;
        return e[15:0];
    endfunction

    // Stage 1: squares. The counts travel along a side line to the end.
    logic [atil_pkg::SQ_W-1:0] r_sqx, r_sqy, r_sqz;
    atil_pkg::t_counts r_side [SD];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sqx <= abs16(r_cnt.cx) * abs16(r_cnt.cx);
            r_sqy <= abs16(r_cnt.cy) * abs16(r_cnt.cy);
            r_sqz <= abs16(r_cnt.cz) * abs16(r_cnt.cz);
            r_side[0] <= r_cnt;
            for (int k = 1; k < SD; k++) r_side[k] <= r_side[k-1];
        end
    end

    // Stage 2: sums of squares, per channel: pitch yz, roll xz, incline xy.
    logic [atil_pkg::SQ_W-1:0] r_sum [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum[0] <= r_sqy + r_sqz;
            r_sum[1] <= r_sqx + r_sqz;
            r_sum[2] <= r_sqx + r_sqy;
        end
    end

    logic [atil_pkg::SQ_W-1:0]   w_rad  [3][SQN+1];
    logic [atil_pkg::REM_W-1:0]  w_rem  [3][SQN+1];
    logic [atil_pkg::ROOT_W-1:0] w_root [3][SQN+1];
    logic signed [atil_pkg::XY_W-1:0] w_x [3][NS+1];
    logic signed [atil_pkg::XY_W-1:0] w_y [3][NS+1];
    logic signed [atil_pkg::Z_W-1:0]  w_z [3][NS+1];
    logic [atil_pkg::ROOT_W-1:0] w_num [3];
    logic [atil_pkg::ROOT_W-1:0] w_den [3];
    atil_pkg::t_counts w_ent;

    assign w_ent = r_side[SQN+1];
    assign w_num[0] = {abs16(w_ent.cx), {atil_pkg::MAG_SHIFT{1'b0}}};
    assign w_den[0] = w_root[0][SQN];
    assign w_num[1] = {abs16(w_ent.cy), {atil_pkg::MAG_SHIFT{1'b0}}};
    assign w_den[1] = w_root[1][SQN];
    assign w_num[2] = w_root[2][SQN];
    assign w_den[2] = {abs16(w_ent.cz), {atil_pkg::MAG_SHIFT{1'b0}}};

    for (genvar c = 0; c < 3; c++) begin : g_ch
        assign w_rad[c][0]  = r_sum[c];
        assign w_rem[c][0]  = '0;
        assign w_root[c][0] = '0;
        for (genvar j = 0; j < SQN; j++) begin : g_sq
            atil_sqrt_cell #(.STEP(SQN - 1 - j)) u_sq (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_rad  (w_rad[c][j]),
                .i_rem  (w_rem[c][j]),
                .i_root (w_root[c][j]),
                .o_rad  (w_rad[c][j+1]),
                .o_rem  (w_rem[c][j+1]),
                .o_root (w_root[c][j+1])
            );
        end
        assign w_x[c][0] = $signed({{(atil_pkg::XY_W-atil_pkg::ROOT_W){1'b0}}, w_den[c]});
        assign w_y[c][0] = $signed({{(atil_pkg::XY_W-atil_pkg::ROOT_W){1'b0}}, w_num[c]});
        assign w_z[c][0] = '0;
        for (genvar j = 0; j < NS; j++) begin : g_rot
            atil_cordic_cell #(.STEP(j)) u_rot (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_x   (w_x[c][j]),
                .i_y   (w_y[c][j]),
                .i_z   (w_z[c][j]),
                .o_x   (w_x[c][j+1]),
                .o_y   (w_y[c][j+1]),
                .o_z   (w_z[c][j+1])
            );
        end
    end

    // Clamp, special cases, rounding, sign and saturation.
    function automatic logic [15:0] finish(input logic signed [31:0] z, input logic numz,
                                           input logic denz, input logic neg);
        logic signed [31:0] q;
        logic signed [31:0] r;
        q = z;
        if (q < 0) q = '0;
        if (q > atil_pkg::RIGHT_ANGLE) q = atil_pkg::RIGHT_ANGLE;
        if (numz) q = '0;
        else if (denz) q = atil_pkg::RIGHT_ANGLE;
        r = (q + HALF) >>> SH;
        if (neg) r = -r;
        if (r > 32'sd32767) r = 32'sd32767;
        if (r < -32'sd32768) r = -32'sd32768;
        return r[15:0];
    endfunction

    atil_pkg::t_counts w_fin;
    logic w_zx, w_zy, w_zz;
    assign w_fin = r_side[SD-1];
    assign w_zx  = (w_fin.cx == '0);
    assign w_zy  = (w_fin.cy == '0);
    assign w_zz  = (w_fin.cz == '0);

    logic [47:0] r_fin_data;
    logic        r_fin_inv;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin_data[15:0]  <= finish(w_z[0][NS], w_zx, w_zy && w_zz, w_fin.cx[15]);
            r_fin_data[31:16] <= finish(w_z[1][NS], w_zy, w_zx && w_zz, w_fin.cy[15]);
            r_fin_data[47:32] <= finish(w_z[2][NS], w_zx && w_zy, w_zz, w_fin.cz[15]);
            r_fin_inv         <= w_zx && w_zy && w_zz;
            r_out_data        <= r_fin_data;
            r_out_user        <= {3{r_fin_inv}};
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: hw/rtl/atil_checker.sv
// Port-level checks for the tilt angle pipeline, bound to the top level.
// Depends only on the ports of accel_tilt_angles.
`timescale 1ns / 1ps

module atil_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // With no result pending the input side is ready for a sample.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // The three flags always agree.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == 3'b000) || (o_m_tuser == 3'b111))
        else $error("invalid flags disagree");

    // An all-zero sample yields zero angles.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 48'd0)
        else $error("nonzero angle on invalid sample");

    // No result leaves right after reset.
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind accel_tilt_angles atil_checker u_atil_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: verif/tb.sv
// Testbench for accel_tilt_angles: streams accelerometer samples through the block
// and checks every pitch, roll and incline result against a built-in angle predictor.
// Depends on the RTL of accel_tilt_angles and its package atil_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int SHIFT      = 6;
    localparam int FRAC       = 8;
    localparam int STAGES     = 16;
    localparam int LATENCY    = 35 + STAGES;
    localparam int N_RANDOM   = 630;
    localparam int MAX_ERR_SHOWN = 10;

    typedef struct packed {
        logic [15:0] incline;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [2:0]  invalid;
    } t_angles;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    logic [47:0] sample_queue[$];
    t_angles     angles_due[$];
    int          mismatches;
    bit          hold_off;
    bit          quiet_phase;
    bit          s_taken;

    accel_tilt_angles #(
        .SAMPLE_SHIFT(SHIFT),
        .ANGLE_FRAC_BITS(FRAC),
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint atan_step_deg(input int i);
        case (i)
            0:  return 754974720;  1:  return 445687602;  2:  return 235489088;
            3:  return 119537938;  4:  return 60000934;   5:  return 30029717;
            6:  return 15018523;   7:  return 7509720;    8:  return 3754917;
            9:  return 1877466;    10: return 938734;     11: return 469367;
            12: return 234684;     13: return 117342;     14: return 58671;
            15: return 29335;      16: return 14668;      17: return 7334;
            18: return 3667;       19: return 1833;       20: return 917;
            21: return 458;        22: return 229;        default: return 115;
        endcase
    endfunction

    function automatic longint axis_count(input logic [15:0] w);
        logic signed [15:0] s;
        s = w;
        return longint'(s >>> SHIFT);
    endfunction

    // Floor square root by bit pairs; the argument stays well below 2^63.
    function automatic longint root_floor(input longint v);
        longint res;
        longint bit_w;
        res = 0;
        bit_w = 64'sd1 <<< 62;
        while (bit_w > v) bit_w = bit_w >>> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >>> 1) + bit_w;
            end else begin
                res = res >>> 1;
            end
            bit_w = bit_w >>> 2;
        end
        return res;
    endfunction

    function automatic longint pair_len(input longint a, input longint b);
        return root_floor((a * a + b * b) <<< 28);
    endfunction

    // Vectoring rotation on (den, num); returns degrees times 2^24 in the first quadrant.
    function automatic longint quadrant_angle(input longint num, input longint den);
        longint x, y, z, xs, ys;
        longint right;
        right = 64'sd90 <<< 24;
        if (num == 0) return 0;
        if (den == 0) return right;
        x = den; y = num; z = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step_deg(i);
            end else begin
                x -= ys; y += xs; z -= atan_step_deg(i);
            end
        end
        if (z < 0) z = 0;
        if (z > right) z = right;
        return z;
    endfunction

    function automatic logic [15:0] to_degrees(input longint z, input bit neg);
        longint r;
        int sh;
        sh = 24 - FRAC;
        r = (z + (64'sd1 <<< (sh - 1))) >>> sh;
        if (neg) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_angles predict_tilt(input logic [47:0] words);
        t_angles res;
        longint cx, cy, cz, ax, ay, az;
        cx = axis_count(words[15:0]);
        cy = axis_count(words[31:16]);
        cz = axis_count(words[47:32]);
        ax = (cx < 0 ? -cx : cx) <<< 14;
        ay = (cy < 0 ? -cy : cy) <<< 14;
        az = (cz < 0 ? -cz : cz) <<< 14;
        res.pitch   = to_degrees(quadrant_angle(ax, pair_len(cy, cz)), cx < 0);
        res.roll    = to_degrees(quadrant_angle(ay, pair_len(cx, cz)), cy < 0);
        res.incline = to_degrees(quadrant_angle(pair_len(cx, cy), az), cz < 0);
        res.invalid = (cx == 0 && cy == 0 && cz == 0) ? 3'b111 : 3'b000;
        return res;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            // Small words, many of which shift down to a count of zero or minus one.
            2: return 16'($urandom_range(0, 255)) - 16'd128;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: new data at the falling edge, so the rising edge sees settled values.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (s_taken) begin
            // Accepted at the last rising edge; the block at the end loads the next one.
        end else if (!i_s_tvalid && !hold_off && sample_queue.size() != 0
                     && (quiet_phase || $urandom_range(0, 99) >= 11)) begin
            i_s_tdata  <= sample_queue.pop_front();
            i_s_tvalid <= 1'b1;
        end
    end

    // The handshake is recorded at the rising edge, where the block takes it.
    always @(posedge i_clk) begin
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) angles_due.push_back(predict_tilt(i_s_tdata));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= quiet_phase || ($urandom_range(0, 99) >= 11);
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_angles got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[47:32], o_m_tdata[31:16], o_m_tdata[15:0], o_m_tuser};
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_ERR_SHOWN)
                    $display("ERROR: unexpected result %h", got);
            end else begin
                want = angles_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_ERR_SHOWN)
                        $display("ERROR: pitch/roll/incline exp %h %h %h inv %b, got %h %h %h inv %b",
                                 want.pitch, want.roll, want.incline, want.invalid,
                                 got.pitch, got.roll, got.incline, got.invalid);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL accel_tilt_angles");
        $finish;
    end

    initial begin
        logic [15:0] edge_words[6];
        int n;
        edge_words = '{16'h8000, 16'h7FFF, 16'h0000, 16'h003F, 16'hFFC0, 16'hFFFF};
        mismatches  = 0;
        hold_off    = 1'b0;
        quiet_phase = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_rst_n     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all zero (invalid), single axes, zero z with nonzero x/y, extremes.
        sample_queue.push_back({16'h0000, 16'h0000, 16'h0000});
        sample_queue.push_back({16'h003F, 16'hFFC1, 16'h0020});
        sample_queue.push_back({16'h0000, 16'h0000, 16'h4000});
        sample_queue.push_back({16'h0000, 16'h0000, 16'hC000});
        sample_queue.push_back({16'h0000, 16'h4000, 16'h0000});
        sample_queue.push_back({16'h0000, 16'hC000, 16'h0000});
        sample_queue.push_back({16'h4000, 16'h0000, 16'h0000});
        sample_queue.push_back({16'hC000, 16'h0000, 16'h0000});
        sample_queue.push_back({16'h0000, 16'h0040, 16'hFFC0});
        sample_queue.push_back({16'h8000, 16'h8000, 16'h8000});
        sample_queue.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
        sample_queue.push_back({16'h8000, 16'h7FFF, 16'h8000});
        sample_queue.push_back({16'hFFC0, 16'h0040, 16'h0040});
        for (int i = 0; i < 8; i++)
            sample_queue.push_back({edge_words[$urandom_range(0, 5)],
                                    edge_words[$urandom_range(0, 5)],
                                    edge_words[$urandom_range(0, 5)]});

        // Back-to-back stretch without idling on either side.
        quiet_phase = 1'b1;
        wait (sample_queue.size() == 0);
        quiet_phase = 1'b0;

        for (int i = 0; i < N_RANDOM; i++) begin
            sample_queue.push_back({rand_word(), rand_word(), rand_word()});
            if (i == N_RANDOM / 2) begin
                wait (sample_queue.size() == 0);
                // Sender holds off until the pipeline has drained completely.
                @(negedge i_clk);
                hold_off = 1'b1;
                @(posedge i_clk);
                wait (!i_s_tvalid && angles_due.size() == 0);
                hold_off = 1'b0;
            end
            if (i == 100) begin
                quiet_phase = 1'b1;
                wait (sample_queue.size() == 0);
                quiet_phase = 1'b0;
            end
        end

        wait (sample_queue.size() == 0 && !i_s_tvalid);
        n = 0;
        while (angles_due.size() != 0 && n < 200_000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatches == 0 && angles_due.size() == 0) begin
            $display("PASS accel_tilt_angles");
        end else begin
            $display("FAIL accel_tilt_angles");
        end
        $finish;
    end

    // Lowering valid is done here so the driver above never assigns it twice per step.
    always @(negedge i_clk) begin
        if (i_rst_n && s_taken) begin
            if (!hold_off && sample_queue.size() != 0
                && (quiet_phase || $urandom_range(0, 99) >= 11)) begin
                i_s_tdata <= sample_queue.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

endmodule
